### src/text_console_cursor_engine_top_defines.svh
// Assertion macros used by the checker file of the cursor engine.
// No dependencies.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TCCE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define TCCE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tcce_pkg.sv
// Types and constants of the text console cursor engine.
// No dependencies.
package tcce_pkg;

  localparam int unsigned CODE_W   = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned ADDR_W   = 11;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned COL_OUT_W = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CHAR_SPACE     = 8'd32;
  localparam logic [CODE_W-1:0] CHAR_NULL      = 8'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ARROW_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ARROW_CODE = 2'd2;

  localparam logic [ATTR_W-1:0] RST_TEXT_ATTRIBUTE   = 8'd15;
  localparam logic [CODE_W-1:0] RST_LEFT_ARROW_CODE  = 8'd128;
  localparam logic [CODE_W-1:0] RST_RIGHT_ARROW_CODE = 8'd129;

  typedef struct packed {
    logic [ATTR_W-1:0] text_attribute;
    logic [CODE_W-1:0] left_arrow_code;
    logic [CODE_W-1:0] right_arrow_code;
  } cfg_t;

  typedef struct packed {
    logic                 cell_write;
    logic [ADDR_W-1:0]    cell_address;
    logic [DATA_W-1:0]    cell_data;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [ADDR_W-1:0]    cursor_offset;
  } result_t;

endpackage

### src/tcce_cfg_regs.sv
// Configuration register file of the cursor engine.
// Depends on tcce_pkg.
module tcce_cfg_regs
  import tcce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CODE_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TEXT_ATTRIBUTE:   cfg_d.text_attribute   = cfg_data_i;
        CFG_LEFT_ARROW_CODE:  cfg_d.left_arrow_code  = cfg_data_i;
        CFG_RIGHT_ARROW_CODE: cfg_d.right_arrow_code = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_attribute   <= RST_TEXT_ATTRIBUTE;
      cfg_q.left_arrow_code  <= RST_LEFT_ARROW_CODE;
      cfg_q.right_arrow_code <= RST_RIGHT_ARROW_CODE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/tcce_cursor.sv
// Cursor state and per-item decode: cell write and new cursor position.
// Depends on tcce_pkg. Keeps a running row base so no multiplier is needed.
module tcce_cursor
  import tcce_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [CODE_W-1:0] code_i,
  input  cfg_t              cfg_i,
  output result_t           res_o
);

  localparam int unsigned COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
  localparam int unsigned POS_W  = $clog2(SCREEN_ROWS * SCREEN_COLUMNS);
  localparam int unsigned SUM_W  = (POS_W > ADDR_W) ? POS_W : ADDR_W;
  localparam int unsigned ROWO_W = (ROW_W > ROW_OUT_W) ? ROW_W : ROW_OUT_W;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [POS_W-1:0] ROW_STEP = POS_W'(SCREEN_COLUMNS);

  logic [COL_W-1:0] col_q, col_d, col_dec, col_sel;
  logic [ROW_W-1:0] row_q, row_d;
  logic [POS_W-1:0] base_q, base_d;
  logic             is_nl, is_tab, is_bs, is_left, is_right, last_col, wr, adv_row;
  logic [CODE_W-1:0] ch;
  logic [SUM_W-1:0]  addr_sum, offs_sum;
  logic [ROWO_W-1:0] row_ext;

  assign is_nl    = (code_i == CHAR_NEWLINE);
  assign is_tab   = (code_i == CHAR_TAB);
  assign is_bs    = (code_i == CHAR_BACKSPACE);
  assign is_left  = !is_tab && (code_i == cfg_i.left_arrow_code);
  assign is_right = !is_tab && (code_i == cfg_i.right_arrow_code);
  assign last_col = (col_q == LAST_COL);
  assign col_dec  = (col_q == '0) ? '0 : col_q - 1'b1;

  always_comb begin
    col_d   = col_q;
    col_sel = col_q;
    adv_row = 1'b0;
    wr      = 1'b0;
    ch      = CHAR_NULL;
    if (is_nl) begin
      col_d   = '0;
      adv_row = 1'b1;
    end else if (is_bs) begin
      col_d   = col_dec;
      col_sel = col_dec;
      wr      = 1'b1;
    end else if (is_left) begin
      col_d = col_dec;
    end else if (is_right) begin
      col_d = last_col ? col_q : col_q + 1'b1;
    end else begin
      wr = 1'b1;
      ch = is_tab ? CHAR_SPACE : code_i;
      if (last_col) begin
        col_d   = '0;
        adv_row = 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    row_d  = row_q;
    base_d = base_q;
    if (adv_row) begin
      if (row_q == LAST_ROW) begin
        row_d  = '0;
        base_d = '0;
      end else begin
        row_d  = row_q + 1'b1;
        base_d = base_q + ROW_STEP;
      end
    end
  end

  assign addr_sum = SUM_W'(base_q) + SUM_W'(col_sel);
  assign offs_sum = SUM_W'(base_d) + SUM_W'(col_d);
  assign row_ext  = ROWO_W'(row_d);

  always_comb begin
    res_o.cell_write    = wr;
    res_o.cell_address  = wr ? addr_sum[ADDR_W-1:0] : '0;
    res_o.cell_data     = wr ? {cfg_i.text_attribute, ch} : '0;
    res_o.cursor_row    = row_ext[ROW_OUT_W-1:0];
    res_o.cursor_column = COL_OUT_W'(col_d);
    res_o.cursor_offset = offs_sum[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else if (en_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

endmodule

### src/text_console_cursor_engine_top.sv
// Top level of the text console cursor engine.
// Depends on tcce_pkg, tcce_cfg_regs and tcce_cursor.
//
// Usage:
//   Input channel: one character code per item (in_valid_i / in_stall_o).
//   Output channel: one result per item (out_valid_o / out_stall_i): cell
//   write strobe, cell address and data, and the new cursor row, column
//   and linear offset.
//   Config channel: cfg_valid_i / cfg_ready_o with a register index and
//   data; ready is always high, unknown indexes are ignored. Write only
//   while no item is in flight.
// Pipeline: the input register takes the item at the accepting edge, and the
//   result register takes its result when the output stage can accept it.
//   Throughput: one item per cycle while the output is not stalled; the
//   cursor update is a combinational increment and compare on the state.
// Reset: cursor at row 0, column 0; attribute 15, arrow codes 128 and 129;
//   both pipeline stages empty.
// Stall: a stalled result holds on the outputs; once the input stage is
//   also full, in_stall_o rises in the same cycle as out_stall_i.
module text_console_cursor_engine_top
  import tcce_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CODE_W-1:0]    char_code_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 cell_write_o,
  output logic [ADDR_W-1:0]    cell_address_o,
  output logic [DATA_W-1:0]    cell_data_o,
  output logic [ROW_OUT_W-1:0] cursor_row_o,
  output logic [COL_OUT_W-1:0] cursor_column_o,
  output logic [ADDR_W-1:0]    cursor_offset_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CODE_W-1:0]    cfg_data_i
);

  cfg_t              cfg;
  result_t           res, res_q;
  logic              s1_valid_q, out_valid_q;
  logic [CODE_W-1:0] s1_code_q;
  logic              out_ready, s1_ready, s1_adv;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = !s1_ready;

  tcce_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tcce_cursor #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .code_i (s1_code_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_code_q <= char_code_i;
    end
    if (s1_adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_write_o    = res_q.cell_write;
  assign cell_address_o  = res_q.cell_address;
  assign cell_data_o     = res_q.cell_data;
  assign cursor_row_o    = res_q.cursor_row;
  assign cursor_column_o = res_q.cursor_column;
  assign cursor_offset_o = res_q.cursor_offset;

endmodule

### src/tcce_checker.sv
// Port-level checks of the cursor engine, bound to the top level.
// Depends on tcce_pkg and text_console_cursor_engine_top_defines.svh.
`include "text_console_cursor_engine_top_defines.svh"

module tcce_checker
  import tcce_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 cell_write_o,
  input logic [ADDR_W-1:0]    cell_address_o,
  input logic [DATA_W-1:0]    cell_data_o,
  input logic [ROW_OUT_W-1:0] cursor_row_o,
  input logic [COL_OUT_W-1:0] cursor_column_o,
  input logic [ADDR_W-1:0]    cursor_offset_o
);

  `TCCE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(cursor_offset_o), "stalled result changed")
  `TCCE_ASSERT(a_no_write_zero, clk_i, rst_ni, out_valid_o && !cell_write_o |-> cell_address_o == '0 && cell_data_o == '0, "idle cell fields not zero")
  `TCCE_ASSERT(a_col_range, clk_i, rst_ni, out_valid_o |-> int'(cursor_column_o) < SCREEN_COLUMNS, "cursor column out of range")
  `TCCE_ASSERT(a_offset, clk_i, rst_ni, out_valid_o && (SCREEN_ROWS <= 32) |-> cursor_offset_o == ADDR_W'(int'(cursor_row_o) * SCREEN_COLUMNS + int'(cursor_column_o)), "cursor offset mismatch")

endmodule

bind text_console_cursor_engine_top tcce_checker #(
  .SCREEN_COLUMNS (SCREEN_COLUMNS),
  .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .cell_write_o    (cell_write_o),
  .cell_address_o  (cell_address_o),
  .cell_data_o     (cell_data_o),
  .cursor_row_o    (cursor_row_o),
  .cursor_column_o (cursor_column_o),
  .cursor_offset_o (cursor_offset_o)
);

### bench/text_console_cursor_engine_top_tb.sv
`timescale 1ns / 100ps
// Testbench of text_console_cursor_engine_top: directed and random character streams,
// checked item by item against a cursor predictor. Depends on tcce_pkg and the RTL.
module text_console_cursor_engine_top_tb;
  import tcce_pkg::*;

  localparam int unsigned COLS = 80;
  localparam int unsigned ROWS = 25;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CODE_W-1:0]    char_code_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 cell_write_o;
  logic [ADDR_W-1:0]    cell_address_o;
  logic [DATA_W-1:0]    cell_data_o;
  logic [ROW_OUT_W-1:0] cursor_row_o;
  logic [COL_OUT_W-1:0] cursor_column_o;
  logic [ADDR_W-1:0]    cursor_offset_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CODE_W-1:0]    cfg_data_i = '0;

  int unsigned row_q = 0;
  int unsigned col_q = 0;
  logic [ATTR_W-1:0] attr_q  = RST_TEXT_ATTRIBUTE;
  logic [CODE_W-1:0] left_q  = RST_LEFT_ARROW_CODE;
  logic [CODE_W-1:0] right_q = RST_RIGHT_ARROW_CODE;

  result_t     cursor_reports_q[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 8;
  int unsigned stall_pct = 8;
  int unsigned quiet_cycles = 0;

  text_console_cursor_engine_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_write_o   (cell_write_o),
    .cell_address_o (cell_address_o),
    .cell_data_o    (cell_data_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_column_o(cursor_column_o),
    .cursor_offset_o(cursor_offset_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned next_row(input int unsigned r);
    return (r + 1 >= ROWS) ? 0 : r + 1;
  endfunction

  // Applies one character to the cursor state and returns what the block reports.
  function automatic result_t advance_cursor(input logic [CODE_W-1:0] code);
    result_t r;
    r = '0;
    if (code == CHAR_NEWLINE) begin
      col_q = 0;
      row_q = next_row(row_q);
    end else if (code == CHAR_BACKSPACE) begin
      if (col_q > 0) col_q = col_q - 1;
      r.cell_write   = 1'b1;
      r.cell_address = ADDR_W'(row_q * COLS + col_q);
      r.cell_data    = {attr_q, CHAR_NULL};
    end else if (code != CHAR_TAB && code == left_q) begin
      if (col_q > 0) col_q = col_q - 1;
    end else if (code != CHAR_TAB && code == right_q) begin
      if (col_q + 1 < COLS) col_q = col_q + 1;
    end else begin
      r.cell_write   = 1'b1;
      r.cell_address = ADDR_W'(row_q * COLS + col_q);
      r.cell_data    = {attr_q, (code == CHAR_TAB) ? CHAR_SPACE : code};
      col_q = col_q + 1;
      if (col_q >= COLS) begin
        col_q = 0;
        row_q = next_row(row_q);
      end
    end
    r.cursor_row    = ROW_OUT_W'(row_q);
    r.cursor_column = COL_OUT_W'(col_q);
    r.cursor_offset = ADDR_W'(row_q * COLS + col_q);
    return r;
  endfunction

  // Valid stays high after acceptance so back-to-back items need no second
  // assignment in the same step; drain_pipe lowers it.
  task automatic send_char(input logic [CODE_W-1:0] code);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    cursor_reports_q.push_back(advance_cursor(code));
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (cursor_reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
    drain_pipe();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TEXT_ATTRIBUTE:   attr_q  = value;
      CFG_LEFT_ARROW_CODE:  left_q  = value;
      CFG_RIGHT_ARROW_CODE: right_q = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cursor_reports_q.size() == 0) begin
        $display("%0t: result with no item pending, expected none actual offset %0d",
                 $time, cursor_offset_o);
        mismatch_count++;
      end else begin
        want = cursor_reports_q.pop_front();
        check_field("cell_write", 32'(want.cell_write), 32'(cell_write_o));
        check_field("cell_address", 32'(want.cell_address), 32'(cell_address_o));
        check_field("cell_data", 32'(want.cell_data), 32'(cell_data_o));
        check_field("cursor_row", 32'(want.cursor_row), 32'(cursor_row_o));
        check_field("cursor_column", 32'(want.cursor_column), 32'(cursor_column_o));
        check_field("cursor_offset", 32'(want.cursor_offset), 32'(cursor_offset_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return CODE_W'($urandom_range(255));
    else if (sel < 60) return CHAR_NEWLINE;
    else if (sel < 66) return CHAR_TAB;
    else if (sel < 76) return CHAR_BACKSPACE;
    else if (sel < 88) return left_q;
    return right_q;
  endfunction

  task automatic test_reset_defaults();
    send_char(8'h41);
    send_char(CHAR_TAB);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(RST_LEFT_ARROW_CODE);
    send_char(RST_RIGHT_ARROW_CODE);
    send_char(CHAR_BACKSPACE);
    send_char(CHAR_NEWLINE);
    send_char(CHAR_BACKSPACE);
    send_char(RST_LEFT_ARROW_CODE);
    send_char(RST_RIGHT_ARROW_CODE);
  endtask

  task automatic test_config_corners();
    write_reg(CFG_TEXT_ATTRIBUTE, 8'h00);
    write_reg(CFG_LEFT_ARROW_CODE, 8'h81);
    write_reg(CFG_RIGHT_ARROW_CODE, 8'h81);
    send_char(8'h81);
    send_char(8'h81);
    write_reg(CFG_LEFT_ARROW_CODE, CHAR_NEWLINE);
    write_reg(CFG_RIGHT_ARROW_CODE, CHAR_TAB);
    send_char(CHAR_TAB);
    send_char(CHAR_NEWLINE);
    send_char(RST_LEFT_ARROW_CODE);
    write_reg(CFG_UNUSED, 8'hFF);
    send_char(8'h42);
    write_reg(CFG_RIGHT_ARROW_CODE, CHAR_BACKSPACE);
    send_char(CHAR_BACKSPACE);
  endtask

  // Mostly single random codes, with runs that push the cursor to the row
  // end, the last row and through full-row wraps.
  task automatic run_text_phase(input logic [ATTR_W-1:0] attr, input logic [CODE_W-1:0] left,
                                input logic [CODE_W-1:0] right, input int unsigned items,
                                input bit quiet);
    int unsigned sent;
    int unsigned run;
    int unsigned kind;
    write_reg(CFG_TEXT_ATTRIBUTE, attr);
    write_reg(CFG_LEFT_ARROW_CODE, left);
    write_reg(CFG_RIGHT_ARROW_CODE, right);
    idle_pct  = quiet ? 0 : 8;
    stall_pct = quiet ? 0 : 8;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 4) begin
        kind = $urandom_range(2);
        run  = (kind == 1) ? $urandom_range(24, 30) : $urandom_range(40, 90);
        repeat (run) begin
          case (kind)
            0: send_char(right_q);
            1: send_char(CHAR_NEWLINE);
            default: send_char(CODE_W'($urandom_range(32, 126)));
          endcase
        end
        sent += run;
      end else begin
        send_char(pick_code());
        sent++;
      end
    end
    idle_pct  = 8;
    stall_pct = 8;
  endtask

  task automatic test_random_text();
    run_text_phase(8'hA5, RST_LEFT_ARROW_CODE, RST_RIGHT_ARROW_CODE, 250, 1'b0);
    run_text_phase(8'h00, 8'h00, 8'hFF, 250, 1'b0);
    run_text_phase(8'hFF, 8'h41, 8'h41, 250, 1'b1);
    run_text_phase(8'h5A, CHAR_NEWLINE, CHAR_BACKSPACE, 200, 1'b0);
    run_text_phase(ATTR_W'($urandom_range(255)), CODE_W'($urandom_range(255)),
                   CODE_W'($urandom_range(255)), 250, 1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_config_corners();
    test_random_text();
    drain_pipe();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
